// ===== rtl/rlchs_pkg.sv =====
package rlchs_pkg;

   // Configuration port geometry: five 32-bit registers at byte addresses 4*i.
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int LIMIT_BITS    = 17;
   localparam int ACTIVE_BITS   = 8;

   localparam logic [2:0] REG_HOP_RIGHT_LIMIT  = 3'd0;
   localparam logic [2:0] REG_HOP_LIMIT        = 3'd1;
   localparam logic [2:0] REG_CHIP_RIGHT_LIMIT = 3'd2;
   localparam logic [2:0] REG_CHIP_LIMIT       = 3'd3;
   localparam logic [2:0] REG_ACTIVE_SITES     = 3'd4;

   localparam logic [LIMIT_BITS-1:0]  RST_HOP_RIGHT_LIMIT  = 17'd3277;
   localparam logic [LIMIT_BITS-1:0]  RST_HOP_LIMIT        = 17'd6554;
   localparam logic [LIMIT_BITS-1:0]  RST_CHIP_RIGHT_LIMIT = 17'd13107;
   localparam logic [LIMIT_BITS-1:0]  RST_CHIP_LIMIT       = 17'd19661;
   localparam logic [ACTIVE_BITS-1:0] RST_ACTIVE_SITES     = 8'd100;

   localparam int MODE_BITS   = 2;
   localparam int SITE_BITS   = 7;
   localparam int VALUE_BITS  = 16;
   localparam int DRAW_BITS   = 16;

   localparam logic [MODE_BITS-1:0] MODE_WRITE = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_SWEEP = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_READ  = 2'd2;

   localparam logic [2:0] ACT_NONE       = 3'd0;
   localparam logic [2:0] ACT_HOP_RIGHT  = 3'd1;
   localparam logic [2:0] ACT_HOP_LEFT   = 3'd2;
   localparam logic [2:0] ACT_CHIP_RIGHT = 3'd3;
   localparam logic [2:0] ACT_CHIP_LEFT  = 3'd4;

   typedef struct packed {
      logic [LIMIT_BITS-1:0] hop_right;
      logic [LIMIT_BITS-1:0] hop;
      logic [LIMIT_BITS-1:0] chip_right;
      logic [LIMIT_BITS-1:0] chip;
   } limits_type;

   typedef struct packed {
      logic load_item;
      logic clear_wr;
      logic start;
      logic act;
      logic tgt_wr;
      logic commit_rd;
      logic sat_clr;
      logic rsp_load;
      logic rsp_done;
   } cmd_type;

   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      logic                 act_taken;
      logic                 rsp_free;
   } status_type;

endpackage

// ===== rtl/rlchs_csr.sv =====
module rlchs_csr #(
   parameter int MAX_SITES = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [rlchs_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [rlchs_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [rlchs_pkg::CSR_DATA_BITS-1:0]  prdata,
   output rlchs_pkg::limits_type                limits,
   output logic [$clog2(MAX_SITES+1)-1:0]       ring_len
);

   localparam int NW = $clog2(MAX_SITES + 1);

   logic [rlchs_pkg::LIMIT_BITS-1:0]  hop_right_ff, hop_ff, chip_right_ff, chip_ff;
   logic [rlchs_pkg::ACTIVE_BITS-1:0] active_ff;
   logic [2:0]                        reg_idx;
   logic                              wr_en;

   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         hop_right_ff  <= rlchs_pkg::RST_HOP_RIGHT_LIMIT;
         hop_ff        <= rlchs_pkg::RST_HOP_LIMIT;
         chip_right_ff <= rlchs_pkg::RST_CHIP_RIGHT_LIMIT;
         chip_ff       <= rlchs_pkg::RST_CHIP_LIMIT;
         active_ff     <= rlchs_pkg::RST_ACTIVE_SITES;
      end else if (wr_en) begin
         case (reg_idx)
            rlchs_pkg::REG_HOP_RIGHT_LIMIT:  hop_right_ff  <= pwdata[16:0];
            rlchs_pkg::REG_HOP_LIMIT:        hop_ff        <= pwdata[16:0];
            rlchs_pkg::REG_CHIP_RIGHT_LIMIT: chip_right_ff <= pwdata[16:0];
            rlchs_pkg::REG_CHIP_LIMIT:       chip_ff       <= pwdata[16:0];
            rlchs_pkg::REG_ACTIVE_SITES:     active_ff     <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         rlchs_pkg::REG_HOP_RIGHT_LIMIT:  prdata = 32'(hop_right_ff);
         rlchs_pkg::REG_HOP_LIMIT:        prdata = 32'(hop_ff);
         rlchs_pkg::REG_CHIP_RIGHT_LIMIT: prdata = 32'(chip_right_ff);
         rlchs_pkg::REG_CHIP_LIMIT:       prdata = 32'(chip_ff);
         rlchs_pkg::REG_ACTIVE_SITES:     prdata = 32'(active_ff);
         default:                         prdata = '0;
      endcase
   end

   assign limits.hop_right  = hop_right_ff;
   assign limits.hop        = hop_ff;
   assign limits.chip_right = chip_right_ff;
   assign limits.chip       = chip_ff;

   // The ring is never shorter than two sites nor longer than the store.
   always_comb begin
      if (int'(active_ff) < 2) begin
         ring_len = NW'(2);
      end else if (int'(active_ff) > MAX_SITES) begin
         ring_len = NW'(MAX_SITES);
      end else begin
         ring_len = NW'(active_ff);
      end
   end

endmodule

// ===== rtl/rlchs_ctrl.sv =====
module rlchs_ctrl #(
   parameter int MAX_SITES = 128
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_stall,
   input  logic [$clog2(MAX_SITES+1)-1:0]               ring_len,
   input  rlchs_pkg::status_type                        status,
   output rlchs_pkg::cmd_type                           cmd,
   output logic [((MAX_SITES > 1) ? $clog2(MAX_SITES) : 1)-1:0] pos,
   output logic [((MAX_SITES > 1) ? $clog2(MAX_SITES) : 1)-1:0] walk
);

   localparam int AW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
   localparam int NW = $clog2(MAX_SITES + 1);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_START  = 4'd2;
   localparam logic [3:0] S_ACT    = 4'd3;
   localparam logic [3:0] S_TGT    = 4'd4;
   localparam logic [3:0] S_END    = 4'd5;
   localparam logic [3:0] S_COMMIT = 4'd6;
   localparam logic [3:0] S_FLUSH  = 4'd7;
   localparam logic [3:0] S_RESP   = 4'd8;

   localparam logic [AW-1:0] WALK_LAST = AW'(MAX_SITES - 1);
   localparam logic [NW:0]   ONE_N     = (NW+1)'(1);

   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] walk_ff, walk_in;
   logic          done_ff, done_in;
   logic [AW-1:0] p_eff;
   logic          last_site;

   // A position left beyond a shortened ring restarts at site zero.
   assign p_eff     = ((NW'(pos_ff)) >= ring_len) ? '0 : pos_ff;
   assign last_site = ((NW+1)'(pos_ff) + ONE_N) >= (NW+1)'(ring_len);
   assign pos       = p_eff;
   assign walk      = walk_ff;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      walk_in      = walk_ff;
      done_in      = done_ff;
      cmd          = '0;
      cmd.rsp_done = done_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            walk_in      = walk_ff + 1'b1;
            if (walk_ff == WALK_LAST) begin
               walk_in  = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               done_in       = 1'b0;
               state_in      = S_START;
            end
         end
         S_START: begin
            cmd.start = 1'b1;
            if (status.mode == rlchs_pkg::MODE_SWEEP) begin
               pos_in   = p_eff;
               state_in = S_ACT;
            end else begin
               state_in = S_RESP;
            end
         end
         S_ACT: begin
            cmd.act  = 1'b1;
            state_in = status.act_taken ? S_TGT : S_END;
         end
         S_TGT: begin
            cmd.tgt_wr = 1'b1;
            state_in   = S_END;
         end
         S_END: begin
            if (last_site) begin
               cmd.sat_clr = 1'b1;
               pos_in      = '0;
               walk_in     = '0;
               done_in     = 1'b1;
               state_in    = S_COMMIT;
            end else begin
               pos_in   = pos_ff + 1'b1;
               state_in = S_RESP;
            end
         end
         S_COMMIT: begin
            cmd.commit_rd = 1'b1;
            walk_in       = walk_ff + 1'b1;
            if (walk_ff == WALK_LAST) begin
               walk_in  = '0;
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            // The write of the last site drains here.
            state_in = S_RESP;
         end
         S_RESP: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         pos_ff   <= '0;
         walk_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         walk_ff  <= walk_in;
         done_ff  <= done_in;
      end
   end

endmodule

// ===== rtl/rlchs_datapath.sv =====
module rlchs_datapath #(
   parameter int MAX_SITES = 128,
   parameter int MASS_BITS = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  rlchs_pkg::cmd_type                           cmd,
   output rlchs_pkg::status_type                        status,
   input  logic [((MAX_SITES > 1) ? $clog2(MAX_SITES) : 1)-1:0] pos,
   input  logic [((MAX_SITES > 1) ? $clog2(MAX_SITES) : 1)-1:0] walk,
   input  logic [$clog2(MAX_SITES+1)-1:0]               ring_len,
   input  rlchs_pkg::limits_type                        limits,
   input  logic [rlchs_pkg::MODE_BITS-1:0]              req_mode,
   input  logic [rlchs_pkg::SITE_BITS-1:0]              req_site,
   input  logic [rlchs_pkg::VALUE_BITS-1:0]             req_mass_value,
   input  logic [rlchs_pkg::DRAW_BITS-1:0]              req_draw,
   output logic                                         rsp_valid,
   input  logic                                         rsp_stall,
   output logic [rlchs_pkg::SITE_BITS-1:0]              rsp_site_out,
   output logic [rlchs_pkg::VALUE_BITS-1:0]             rsp_mass_out,
   output logic                                         rsp_sweep_done,
   output logic                                         rsp_saturated
);

   localparam int AW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
   localparam int NW = $clog2(MAX_SITES + 1);
   localparam int DB = MASS_BITS + 2;
   localparam int LIMIT_W = rlchs_pkg::LIMIT_BITS;

   localparam logic signed [DB:0]   MASS_MAX_S = $signed({3'b000, {MASS_BITS{1'b1}}});
   localparam logic signed [DB-1:0] CHIP_UNIT  = DB'(1);
   localparam logic [NW-1:0]        ONE_N      = NW'(1);

   logic [MASS_BITS-1:0]    mass_mem  [MAX_SITES];
   logic signed [DB-1:0]    delta_mem [MAX_SITES];

   logic [rlchs_pkg::MODE_BITS-1:0] mode_ff;
   logic [rlchs_pkg::SITE_BITS-1:0] site_ff;
   logic [MASS_BITS-1:0]            mval_ff;
   logic [rlchs_pkg::DRAW_BITS-1:0] draw_ff;
   logic                            in_range_ff;
   logic [AW-1:0]                   p_ff;
   logic [AW-1:0]                   tgt_ff;
   logic signed [DB-1:0]            amt_ff;
   logic [MASS_BITS-1:0]            mass_rd_ff;
   logic signed [DB-1:0]            delta_rd_ff;
   logic                            pend_ff;
   logic [AW-1:0]                   caddr_ff;
   logic                            sat_ff;
   logic                            rsp_valid_ff;
   logic [rlchs_pkg::SITE_BITS-1:0] site_out_ff;
   logic [rlchs_pkg::VALUE_BITS-1:0] mass_out_ff;
   logic                            done_out_ff;
   logic                            sat_out_ff;

   logic [AW-1:0]                   site_addr;
   logic [LIMIT_W-1:0]              draw_x;
   logic [2:0]                      action;
   logic                            taken;
   logic [AW-1:0]                   right_idx, left_idx, tgt_next;
   logic signed [DB-1:0]            amt_now;
   logic signed [DB:0]              sum_c;
   logic [MASS_BITS-1:0]            clamp_val;
   logic                            clamp_hit;
   logic                            mass_re, delta_re;
   logic [AW-1:0]                   mass_raddr, delta_raddr;
   logic                            mass_we, delta_we;
   logic [AW-1:0]                   mass_waddr, delta_waddr;
   logic [MASS_BITS-1:0]            mass_wdata;
   logic signed [DB-1:0]            delta_wdata;
   logic                            is_sweep, is_read, is_write;

   assign site_addr = AW'(site_ff);
   assign is_sweep  = (mode_ff == rlchs_pkg::MODE_SWEEP);
   assign is_read   = (mode_ff == rlchs_pkg::MODE_READ);
   assign is_write  = (mode_ff == rlchs_pkg::MODE_WRITE);
   assign draw_x    = LIMIT_W'(draw_ff);

   // Windows are tried in order; the first that matches wins and bounds never act.
   always_comb begin
      if (draw_x != '0 && draw_x < limits.hop_right) begin
         action = rlchs_pkg::ACT_HOP_RIGHT;
      end else if (draw_x > limits.hop_right && draw_x < limits.hop) begin
         action = rlchs_pkg::ACT_HOP_LEFT;
      end else if (draw_x > limits.hop && draw_x < limits.chip_right) begin
         action = rlchs_pkg::ACT_CHIP_RIGHT;
      end else if (draw_x > limits.chip_right && draw_x < limits.chip) begin
         action = rlchs_pkg::ACT_CHIP_LEFT;
      end else begin
         action = rlchs_pkg::ACT_NONE;
      end
   end

   assign taken     = (mass_rd_ff != '0) && (action != rlchs_pkg::ACT_NONE);
   assign right_idx = ((NW'(p_ff) + ONE_N) == ring_len) ? '0 : AW'(p_ff + 1'b1);
   assign left_idx  = (p_ff == '0) ? AW'(ring_len - ONE_N) : AW'(p_ff - 1'b1);

   always_comb begin
      case (action)
         rlchs_pkg::ACT_HOP_RIGHT: begin
            tgt_next = right_idx;
            amt_now  = $signed({2'b00, mass_rd_ff});
         end
         rlchs_pkg::ACT_HOP_LEFT: begin
            tgt_next = left_idx;
            amt_now  = $signed({2'b00, mass_rd_ff});
         end
         rlchs_pkg::ACT_CHIP_RIGHT: begin
            tgt_next = right_idx;
            amt_now  = CHIP_UNIT;
         end
         rlchs_pkg::ACT_CHIP_LEFT: begin
            tgt_next = left_idx;
            amt_now  = CHIP_UNIT;
         end
         default: begin
            tgt_next = right_idx;
            amt_now  = '0;
         end
      endcase
   end

   // Commit arithmetic: mass plus delta, held to the unsigned mass range.
   assign sum_c = $signed({3'b000, mass_rd_ff}) + (DB+1)'(delta_rd_ff);

   always_comb begin
      if (sum_c < 0) begin
         clamp_val = '0;
         clamp_hit = 1'b1;
      end else if (sum_c > MASS_MAX_S) begin
         clamp_val = '1;
         clamp_hit = 1'b1;
      end else begin
         clamp_val = sum_c[MASS_BITS-1:0];
         clamp_hit = 1'b0;
      end
   end

   assign mass_re     = cmd.commit_rd || (cmd.start && (is_sweep || is_read));
   assign mass_raddr  = cmd.commit_rd ? walk : (is_sweep ? pos : site_addr);
   assign delta_re    = cmd.commit_rd || (cmd.start && is_sweep) || (cmd.act && taken);
   assign delta_raddr = cmd.commit_rd ? walk : (cmd.act ? tgt_next : pos);

   always_comb begin
      mass_we    = 1'b0;
      mass_waddr = walk;
      mass_wdata = '0;
      if (cmd.clear_wr) begin
         mass_we = 1'b1;
      end else if (pend_ff) begin
         mass_we    = 1'b1;
         mass_waddr = caddr_ff;
         mass_wdata = clamp_val;
      end else if (cmd.start && is_write && in_range_ff) begin
         mass_we    = 1'b1;
         mass_waddr = site_addr;
         mass_wdata = mval_ff;
      end
   end

   always_comb begin
      delta_we    = 1'b0;
      delta_waddr = walk;
      delta_wdata = '0;
      if (cmd.clear_wr) begin
         delta_we = 1'b1;
      end else if (pend_ff) begin
         delta_we    = 1'b1;
         delta_waddr = caddr_ff;
      end else if (cmd.act && taken) begin
         delta_we    = 1'b1;
         delta_waddr = p_ff;
         delta_wdata = delta_rd_ff - amt_now;
      end else if (cmd.tgt_wr) begin
         delta_we    = 1'b1;
         delta_waddr = tgt_ff;
         delta_wdata = delta_rd_ff + amt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mass_we) begin
         mass_mem[mass_waddr] <= mass_wdata;
      end
      if (mass_re) begin
         mass_rd_ff <= mass_mem[mass_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (delta_we) begin
         delta_mem[delta_waddr] <= delta_wdata;
      end
      if (delta_re) begin
         delta_rd_ff <= delta_mem[delta_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         mode_ff     <= req_mode;
         site_ff     <= req_site;
         mval_ff     <= MASS_BITS'(req_mass_value);
         draw_ff     <= req_draw;
         in_range_ff <= (int'(req_site) < MAX_SITES);
      end
      if (cmd.start) begin
         p_ff <= pos;
      end
      if (cmd.act) begin
         tgt_ff <= tgt_next;
         amt_ff <= amt_now;
      end
      caddr_ff <= walk;
      if (cmd.rsp_load) begin
         site_out_ff <= '0;
         mass_out_ff <= '0;
         done_out_ff <= 1'b0;
         sat_out_ff  <= 1'b0;
         if (is_write) begin
            site_out_ff <= site_ff;
         end else if (is_read) begin
            site_out_ff <= site_ff;
            mass_out_ff <= in_range_ff ? rlchs_pkg::VALUE_BITS'(mass_rd_ff) : '0;
         end else if (is_sweep) begin
            site_out_ff <= rlchs_pkg::SITE_BITS'(p_ff);
            done_out_ff <= cmd.rsp_done;
            sat_out_ff  <= cmd.rsp_done && sat_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.commit_rd;
         if (cmd.sat_clr) begin
            sat_ff <= 1'b0;
         end else if (pend_ff && clamp_hit) begin
            sat_ff <= 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.mode      = mode_ff;
   assign status.act_taken = taken;
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_site_out   = site_out_ff;
   assign rsp_mass_out   = mass_out_ff;
   assign rsp_sweep_done = done_out_ff;
   assign rsp_saturated  = sat_out_ff;

endmodule

// ===== rtl/ring_lattice_chip_hop_sweep.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  mode, site, mass_value, draw
// rsp       out        rsp_valid/rsp_stall  site_out, mass_out, sweep_done, saturated
// csr       in/out     psel/penable/pready  paddr, pwdata, prdata (32-bit registers)
//
// One item is in work at a time. Writes, reads and unused codes pass through a start
// state and a response state; a sweep draw adds an action state and an end state, and
// a target state when the draw moves mass, set by the read-modify-write of two delta
// store entries through one memory port.
// The last ring site's draw adds a commit walk over every store entry and a flush.
// After reset a clearing pass zeroes both stores; req_stall is high meanwhile.
// A stalled result is held in the output register; the next transfer is taken meanwhile.
module ring_lattice_chip_hop_sweep #(
   parameter int MAX_SITES = 128,
   parameter int MASS_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rlchs_pkg::MODE_BITS-1:0]     req_mode,
   input  logic [rlchs_pkg::SITE_BITS-1:0]     req_site,
   input  logic [rlchs_pkg::VALUE_BITS-1:0]    req_mass_value,
   input  logic [rlchs_pkg::DRAW_BITS-1:0]     req_draw,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rlchs_pkg::SITE_BITS-1:0]     rsp_site_out,
   output logic [rlchs_pkg::VALUE_BITS-1:0]    rsp_mass_out,
   output logic                                rsp_sweep_done,
   output logic                                rsp_saturated,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rlchs_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [rlchs_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [rlchs_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                pready
);

   localparam int AW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
   localparam int NW = $clog2(MAX_SITES + 1);

   rlchs_pkg::limits_type limits;
   rlchs_pkg::cmd_type    cmd;
   rlchs_pkg::status_type status;
   logic [NW-1:0]         ring_len;
   logic [AW-1:0]         pos;
   logic [AW-1:0]         walk;

   assign pready = 1'b1;

   rlchs_csr #(
      .MAX_SITES(MAX_SITES)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .limits   (limits),
      .ring_len (ring_len)
   );

   rlchs_ctrl #(
      .MAX_SITES(MAX_SITES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .ring_len  (ring_len),
      .status    (status),
      .cmd       (cmd),
      .pos       (pos),
      .walk      (walk)
   );

   rlchs_datapath #(
      .MAX_SITES(MAX_SITES),
      .MASS_BITS(MASS_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .pos            (pos),
      .walk           (walk),
      .ring_len       (ring_len),
      .limits         (limits),
      .req_mode       (req_mode),
      .req_site       (req_site),
      .req_mass_value (req_mass_value),
      .req_draw       (req_draw),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_site_out   (rsp_site_out),
      .rsp_mass_out   (rsp_mass_out),
      .rsp_sweep_done (rsp_sweep_done),
      .rsp_saturated  (rsp_saturated)
   );

endmodule

// ===== rtl/rlchs_checker.sv =====
module rlchs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_sweep_done,
   input logic rsp_saturated
);

   // The clearing pass follows reset, so no transfer is taken straight after it.
   a_reset_stall: assert property (@(posedge clock) reset |=> req_stall)
      else $error("input taken straight after reset");

   // One item at a time: a transfer is always followed by a busy cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second transfer while an item is in work");

   // A new result only comes out of an item in work.
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without an item in work");

   // Saturation is only reported by the result that commits a sweep.
   a_sat_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> rsp_sweep_done)
      else $error("saturation reported outside a commit");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

endmodule

bind ring_lattice_chip_hop_sweep rlchs_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sweep_done (rsp_sweep_done),
   .rsp_saturated  (rsp_saturated)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   localparam logic [rlchs_pkg::MODE_BITS-1:0] MODE_SPARE = 2'd3;
   localparam int SITE_COUNT  = 128;
   localparam int MASS_MAX    = (1 << rlchs_pkg::VALUE_BITS) - 1;
   localparam int LIMIT_ONE   = 65536;
   localparam int STUCK_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [rlchs_pkg::MODE_BITS-1:0]  mode;
      logic [rlchs_pkg::SITE_BITS-1:0]  site;
      logic [rlchs_pkg::VALUE_BITS-1:0] mass_value;
      logic [rlchs_pkg::DRAW_BITS-1:0]  draw;
   } lattice_req_type;

   typedef struct packed {
      logic [rlchs_pkg::SITE_BITS-1:0]  site_out;
      logic [rlchs_pkg::VALUE_BITS-1:0] mass_out;
      logic                             sweep_done;
      logic                             saturated;
   } lattice_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid      = 1'b0;
   logic                                req_stall;
   logic [rlchs_pkg::MODE_BITS-1:0]     req_mode       = '0;
   logic [rlchs_pkg::SITE_BITS-1:0]     req_site       = '0;
   logic [rlchs_pkg::VALUE_BITS-1:0]    req_mass_value = '0;
   logic [rlchs_pkg::DRAW_BITS-1:0]     req_draw       = '0;
   logic                                rsp_valid;
   logic                                rsp_stall      = 1'b0;
   logic [rlchs_pkg::SITE_BITS-1:0]     rsp_site_out;
   logic [rlchs_pkg::VALUE_BITS-1:0]    rsp_mass_out;
   logic                                rsp_sweep_done;
   logic                                rsp_saturated;
   logic                                psel           = 1'b0;
   logic                                penable        = 1'b0;
   logic                                pwrite         = 1'b0;
   logic [rlchs_pkg::CSR_ADDR_BITS-1:0] paddr          = '0;
   logic [rlchs_pkg::CSR_DATA_BITS-1:0] pwdata         = '0;
   logic [rlchs_pkg::CSR_DATA_BITS-1:0] prdata;
   logic                                pready;

   // Shadow of the block: masses, pending changes, sweep cursor and registers.
   bit   [rlchs_pkg::VALUE_BITS-1:0]  lattice_mass  [SITE_COUNT];
   int                                lattice_delta [SITE_COUNT];
   int                                sweep_cursor  = 0;
   logic [rlchs_pkg::LIMIT_BITS-1:0]  cfg_hop_right  = rlchs_pkg::RST_HOP_RIGHT_LIMIT;
   logic [rlchs_pkg::LIMIT_BITS-1:0]  cfg_hop        = rlchs_pkg::RST_HOP_LIMIT;
   logic [rlchs_pkg::LIMIT_BITS-1:0]  cfg_chip_right = rlchs_pkg::RST_CHIP_RIGHT_LIMIT;
   logic [rlchs_pkg::LIMIT_BITS-1:0]  cfg_chip       = rlchs_pkg::RST_CHIP_LIMIT;
   logic [rlchs_pkg::ACTIVE_BITS-1:0] cfg_ring       = rlchs_pkg::RST_ACTIVE_SITES;

   lattice_rsp_type outcome_queue[$];
   int mismatch_count = 0;
   int stuck_cycles   = 0;
   int tx_idle_pct    = 0;
   int rx_idle_pct    = 0;
   int rx_hold_len    = 0;

   ring_lattice_chip_hop_sweep dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_site       (req_site),
      .req_mass_value (req_mass_value),
      .req_draw       (req_draw),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_site_out   (rsp_site_out),
      .rsp_mass_out   (rsp_mass_out),
      .rsp_sweep_done (rsp_sweep_done),
      .rsp_saturated  (rsp_saturated),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always #10 clock = ~clock;

   task automatic flag_mismatch(input string what, input int unsigned want,
                                input int unsigned got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t mismatch in %s: expected %0h, got %0h", $realtime, what, want, got);
      end
   endtask

   function automatic int ring_length();
      int n;
      n = cfg_ring;
      if (n < 2) n = 2;
      if (n > SITE_COUNT) n = SITE_COUNT;
      return n;
   endfunction

   // Windows are tried in order, so with unsorted limits the first match wins.
   function automatic logic [2:0] choose_move(input logic [rlchs_pkg::DRAW_BITS-1:0] x);
      int d;
      d = x;
      if (d > 0 && d < cfg_hop_right) return rlchs_pkg::ACT_HOP_RIGHT;
      if (d > cfg_hop_right && d < cfg_hop) return rlchs_pkg::ACT_HOP_LEFT;
      if (d > cfg_hop && d < cfg_chip_right) return rlchs_pkg::ACT_CHIP_RIGHT;
      if (d > cfg_chip_right && d < cfg_chip) return rlchs_pkg::ACT_CHIP_LEFT;
      return rlchs_pkg::ACT_NONE;
   endfunction

   function automatic lattice_rsp_type lattice_outcome(input lattice_req_type it);
      lattice_rsp_type r;
      int n, p, right_site, left_site, amt, sum;
      r = '0;
      case (it.mode)
         rlchs_pkg::MODE_WRITE: begin
            lattice_mass[it.site] = it.mass_value;
            r.site_out = it.site;
         end
         rlchs_pkg::MODE_READ: begin
            r.site_out = it.site;
            r.mass_out = lattice_mass[it.site];
         end
         rlchs_pkg::MODE_SWEEP: begin
            n = ring_length();
            p = (sweep_cursor >= n) ? 0 : sweep_cursor;
            amt = lattice_mass[p];
            right_site = (p + 1 == n) ? 0 : p + 1;
            left_site = (p == 0) ? n - 1 : p - 1;
            if (amt > 0) begin
               case (choose_move(it.draw))
                  rlchs_pkg::ACT_HOP_RIGHT: begin
                     lattice_delta[right_site] += amt;
                     lattice_delta[p] -= amt;
                  end
                  rlchs_pkg::ACT_HOP_LEFT: begin
                     lattice_delta[left_site] += amt;
                     lattice_delta[p] -= amt;
                  end
                  rlchs_pkg::ACT_CHIP_RIGHT: begin
                     lattice_delta[right_site] += 1;
                     lattice_delta[p] -= 1;
                  end
                  rlchs_pkg::ACT_CHIP_LEFT: begin
                     lattice_delta[left_site] += 1;
                     lattice_delta[p] -= 1;
                  end
                  default: ;
               endcase
            end
            r.site_out = 7'(p);
            if (p + 1 >= n) begin
               // The commit covers every site, not just the active ring.
               r.sweep_done = 1'b1;
               for (int i = 0; i < SITE_COUNT; i++) begin
                  sum = int'(lattice_mass[i]) + lattice_delta[i];
                  if (sum < 0) begin
                     sum = 0;
                     r.saturated = 1'b1;
                  end
                  if (sum > MASS_MAX) begin
                     sum = MASS_MAX;
                     r.saturated = 1'b1;
                  end
                  lattice_mass[i] = 16'(sum);
                  lattice_delta[i] = 0;
               end
               sweep_cursor = 0;
            end else begin
               sweep_cursor = p + 1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Result checking.
   always @(posedge clock) begin : check_rsp
      lattice_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcome_queue.size() == 0) begin
            flag_mismatch("unexpected result", 0, rsp_site_out);
         end else begin
            want = outcome_queue.pop_front();
            if (rsp_site_out !== want.site_out)
               flag_mismatch("site_out", want.site_out, rsp_site_out);
            if (rsp_mass_out !== want.mass_out)
               flag_mismatch("mass_out", want.mass_out, rsp_mass_out);
            if (rsp_sweep_done !== want.sweep_done)
               flag_mismatch("sweep_done", want.sweep_done, rsp_sweep_done);
            if (rsp_saturated !== want.saturated)
               flag_mismatch("saturated", want.saturated, rsp_saturated);
         end
      end
   end

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (rx_hold_len > 0) begin
         rsp_stall <= 1'b1;
         rx_hold_len = rx_hold_len - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles = stuck_cycles + 1;
         if (stuck_cycles == STUCK_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic csr_access(input logic [2:0] idx, input logic wr,
                             input logic [rlchs_pkg::CSR_DATA_BITS-1:0] wdata,
                             output logic [rlchs_pkg::CSR_DATA_BITS-1:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {idx, 2'b00};
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input int unsigned value);
      logic [rlchs_pkg::CSR_DATA_BITS-1:0] rd, want;
      csr_access(idx, 1'b1, value, rd);
      case (idx)
         rlchs_pkg::REG_HOP_RIGHT_LIMIT:
            cfg_hop_right  = value[rlchs_pkg::LIMIT_BITS-1:0];
         rlchs_pkg::REG_HOP_LIMIT:
            cfg_hop        = value[rlchs_pkg::LIMIT_BITS-1:0];
         rlchs_pkg::REG_CHIP_RIGHT_LIMIT:
            cfg_chip_right = value[rlchs_pkg::LIMIT_BITS-1:0];
         rlchs_pkg::REG_CHIP_LIMIT:
            cfg_chip       = value[rlchs_pkg::LIMIT_BITS-1:0];
         default:
            cfg_ring       = value[rlchs_pkg::ACTIVE_BITS-1:0];
      endcase
      want = (idx == rlchs_pkg::REG_ACTIVE_SITES) ? 32'(value[rlchs_pkg::ACTIVE_BITS-1:0])
                                                  : 32'(value[rlchs_pkg::LIMIT_BITS-1:0]);
      csr_access(idx, 1'b0, '0, rd);
      if (rd !== want) flag_mismatch("register readback", want, rd);
   endtask

   task automatic set_limits(input int a, input int b, input int c, input int d);
      csr_write(rlchs_pkg::REG_HOP_RIGHT_LIMIT, a);
      csr_write(rlchs_pkg::REG_HOP_LIMIT, b);
      csr_write(rlchs_pkg::REG_CHIP_RIGHT_LIMIT, c);
      csr_write(rlchs_pkg::REG_CHIP_LIMIT, d);
   endtask

   // Valid is only lowered by a gap or by a drain, never in the step it is raised.
   task automatic send_item(input lattice_req_type it);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= it.mode;
      req_site <= it.site;
      req_mass_value <= it.mass_value;
      req_draw <= it.draw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      outcome_queue.push_back(lattice_outcome(it));
   endtask

   task automatic wait_drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (outcome_queue.size() != 0) @(posedge clock);
   endtask

   function automatic lattice_req_type random_item(input logic [rlchs_pkg::MODE_BITS-1:0] m);
      lattice_req_type it;
      it.mode = m;
      it.site = 7'($urandom_range(0, 127));
      it.mass_value = 16'($urandom_range(0, 65535));
      it.draw = 16'($urandom_range(0, 65535));
      return it;
   endfunction

   task automatic put_mass(input int site, input int value);
      lattice_req_type it;
      it = random_item(rlchs_pkg::MODE_WRITE);
      it.site = 7'(site);
      it.mass_value = 16'(value);
      send_item(it);
   endtask

   task automatic get_mass(input int site);
      lattice_req_type it;
      it = random_item(rlchs_pkg::MODE_READ);
      it.site = 7'(site);
      send_item(it);
   endtask

   task automatic do_draw(input int d);
      lattice_req_type it;
      it = random_item(rlchs_pkg::MODE_SWEEP);
      it.draw = 16'(d);
      send_item(it);
   endtask

   function automatic int pick_mass();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return $urandom_range(1, 12);
         5:             return 0;
         6:             return MASS_MAX;
         7:             return $urandom_range(MASS_MAX - 40, MASS_MAX);
         default:       return $urandom_range(0, MASS_MAX);
      endcase
   endfunction

   // Draws are biased towards the action windows and their boundaries.
   function automatic int pick_draw();
      int lim_val, d;
      case ($urandom_range(3))
         0:       lim_val = cfg_hop_right;
         1:       lim_val = cfg_hop;
         2:       lim_val = cfg_chip_right;
         default: lim_val = cfg_chip;
      endcase
      case ($urandom_range(9))
         0, 1, 2, 3: d = $urandom_range(0, 65535);
         4, 5, 6:    d = $urandom_range(0, lim_val);
         7, 8:       d = lim_val + $urandom_range(0, 2) - 1;
         default:    d = $urandom_range(0, 1) * 65535;
      endcase
      if (d < 0) d = 0;
      if (d > 65535) d = 65535;
      return d;
   endfunction

   task automatic randomize_config;
      int a, b, c, d;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: csr_write(rlchs_pkg::REG_ACTIVE_SITES, $urandom_range(2, 12));
         5:             csr_write(rlchs_pkg::REG_ACTIVE_SITES, $urandom_range(0, 1));
         6:             csr_write(rlchs_pkg::REG_ACTIVE_SITES, $urandom_range(13, 127));
         7:             csr_write(rlchs_pkg::REG_ACTIVE_SITES, SITE_COUNT);
         8:             csr_write(rlchs_pkg::REG_ACTIVE_SITES, $urandom_range(129, 255));
         default:       csr_write(rlchs_pkg::REG_ACTIVE_SITES, rlchs_pkg::RST_ACTIVE_SITES);
      endcase
      case ($urandom_range(4))
         0: begin
            a = rlchs_pkg::RST_HOP_RIGHT_LIMIT;
            b = rlchs_pkg::RST_HOP_LIMIT;
            c = rlchs_pkg::RST_CHIP_RIGHT_LIMIT;
            d = rlchs_pkg::RST_CHIP_LIMIT;
         end
         1: begin
            a = $urandom_range(0, 16384);
            b = a + $urandom_range(0, 16384);
            c = b + $urandom_range(0, 16384);
            d = c + $urandom_range(0, 16384);
         end
         2: begin
            a = $urandom_range(0, LIMIT_ONE);
            b = $urandom_range(0, LIMIT_ONE);
            c = $urandom_range(0, LIMIT_ONE);
            d = $urandom_range(0, LIMIT_ONE);
         end
         3: begin
            a = $urandom_range(0, 1) * LIMIT_ONE;
            b = $urandom_range(0, 1) * LIMIT_ONE;
            c = $urandom_range(0, 1) * LIMIT_ONE;
            d = $urandom_range(0, 1) * LIMIT_ONE;
         end
         default: begin
            a = $urandom_range(40000, LIMIT_ONE);
            b = $urandom_range(a, LIMIT_ONE);
            c = $urandom_range(b, LIMIT_ONE);
            d = $urandom_range(c, LIMIT_ONE);
         end
      endcase
      set_limits(a, b, c, d);
   endtask

   task automatic test_reset_values;
      logic [rlchs_pkg::CSR_DATA_BITS-1:0] rd;
      csr_access(rlchs_pkg::REG_HOP_RIGHT_LIMIT, 1'b0, '0, rd);
      if (rd !== 32'(rlchs_pkg::RST_HOP_RIGHT_LIMIT))
         flag_mismatch("reset value", rlchs_pkg::RST_HOP_RIGHT_LIMIT, rd);
      csr_access(rlchs_pkg::REG_HOP_LIMIT, 1'b0, '0, rd);
      if (rd !== 32'(rlchs_pkg::RST_HOP_LIMIT))
         flag_mismatch("reset value", rlchs_pkg::RST_HOP_LIMIT, rd);
      csr_access(rlchs_pkg::REG_CHIP_RIGHT_LIMIT, 1'b0, '0, rd);
      if (rd !== 32'(rlchs_pkg::RST_CHIP_RIGHT_LIMIT))
         flag_mismatch("reset value", rlchs_pkg::RST_CHIP_RIGHT_LIMIT, rd);
      csr_access(rlchs_pkg::REG_CHIP_LIMIT, 1'b0, '0, rd);
      if (rd !== 32'(rlchs_pkg::RST_CHIP_LIMIT))
         flag_mismatch("reset value", rlchs_pkg::RST_CHIP_LIMIT, rd);
      csr_access(rlchs_pkg::REG_ACTIVE_SITES, 1'b0, '0, rd);
      if (rd !== 32'(rlchs_pkg::RST_ACTIVE_SITES))
         flag_mismatch("reset value", rlchs_pkg::RST_ACTIVE_SITES, rd);
   endtask

   task automatic test_write_read;
      put_mass(127, MASS_MAX);
      get_mass(127);
      send_item(random_item(MODE_SPARE));
   endtask

   // One site per action on a ring of four, each draw just inside its window.
   task automatic test_actions;
      wait_drain();
      csr_write(rlchs_pkg::REG_ACTIVE_SITES, 4);
      for (int i = 0; i < 4; i++) put_mass(i, 10 * (i + 1));
      do_draw(1);
      do_draw(rlchs_pkg::RST_HOP_RIGHT_LIMIT + 1);
      do_draw(rlchs_pkg::RST_HOP_LIMIT + 1);
      do_draw(rlchs_pkg::RST_CHIP_LIMIT - 1);
   endtask

   // A ring length of one is used as two. High clamp first, then a low clamp
   // caused by a write that lowers a mass after its chip was recorded.
   task automatic test_saturation;
      wait_drain();
      csr_write(rlchs_pkg::REG_ACTIVE_SITES, 1);
      put_mass(0, MASS_MAX);
      put_mass(1, MASS_MAX);
      do_draw(1);
      do_draw(65535);
      put_mass(0, 5);
      put_mass(1, 7);
      do_draw(rlchs_pkg::RST_HOP_LIMIT + 1);
      put_mass(0, 0);
      do_draw(0);
   endtask

   task automatic test_limit_order;
      wait_drain();
      csr_write(rlchs_pkg::REG_ACTIVE_SITES, 0);
      set_limits(30000, 10000, 50000, 40000);
      put_mass(0, 3);
      put_mass(1, 7);
      do_draw(20000);
      do_draw(35000);
      wait_drain();
      set_limits(LIMIT_ONE, LIMIT_ONE, LIMIT_ONE, LIMIT_ONE);
      do_draw(65535);
      wait_drain();
      set_limits(0, 0, 0, 0);
      do_draw(1);
   endtask

   // Draws on the boundaries do nothing; then the ring is shortened mid-sweep.
   task automatic test_ring_wrap;
      wait_drain();
      csr_write(rlchs_pkg::REG_ACTIVE_SITES, 10);
      set_limits(rlchs_pkg::RST_HOP_RIGHT_LIMIT, rlchs_pkg::RST_HOP_LIMIT,
                 rlchs_pkg::RST_CHIP_RIGHT_LIMIT, rlchs_pkg::RST_CHIP_LIMIT);
      do_draw(0);
      do_draw(rlchs_pkg::RST_HOP_RIGHT_LIMIT);
      do_draw(rlchs_pkg::RST_HOP_LIMIT);
      do_draw(rlchs_pkg::RST_CHIP_RIGHT_LIMIT);
      do_draw(rlchs_pkg::RST_CHIP_LIMIT);
      wait_drain();
      csr_write(rlchs_pkg::REG_ACTIVE_SITES, 3);
      do_draw(pick_draw());
      wait_drain();
      csr_write(rlchs_pkg::REG_ACTIVE_SITES, 255);
      do_draw(pick_draw());
   endtask

   task automatic test_random_traffic(input int item_goal, input int tx_pct,
                                      input int rx_pct, input bit hold_off);
      int sent, block, n, k;
      bit held;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      sent = 0;
      held = 1'b0;
      while (sent < item_goal) begin
         wait_drain();
         randomize_config();
         n = ring_length();
         block = $urandom_range(30, 90);
         k = $urandom_range(1, n);
         for (int j = 0; j < block; j++) begin
            if (hold_off && !held && sent + j >= item_goal / 2) begin
               rx_hold_len = HOLD_CYCLES;
               held = 1'b1;
            end
            // Populate the ring first so that the sweep has mass to move.
            if (j < k) begin
               put_mass($urandom_range(0, n - 1), pick_mass());
            end else begin
               case ($urandom_range(24))
                  0, 1:    put_mass($urandom_range(0, 127), pick_mass());
                  2, 3:    get_mass($urandom_range(0, 127));
                  4:       send_item(random_item(MODE_SPARE));
                  default: do_draw(pick_draw());
               endcase
            end
         end
         sent += block;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // The block clears its stores after reset and stalls until done.
      while (req_stall !== 1'b0) @(posedge clock);
      test_reset_values();
      test_write_read();
      test_actions();
      test_saturation();
      test_limit_order();
      test_ring_wrap();
      test_random_traffic(400, 19, 82, 1'b0);
      test_random_traffic(400, 82, 19, 1'b0);
      test_random_traffic(400, 0, 0, 1'b1);
      wait_drain();
      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && outcome_queue.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
